[hdl/depth_to_point_backprojection_top_defines.svh]
// assertion macros shared by the back-projection block
`ifndef DEPTH_TO_POINT_BACKPROJECTION_TOP_DEFINES_SVH
`define DEPTH_TO_POINT_BACKPROJECTION_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define DTPB_ASSERT_SAME(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("dtpb assertion failed");
// next-cycle implication, disabled during reset
`define DTPB_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("dtpb assertion failed");
`else
`define DTPB_ASSERT_SAME(lbl, clk, rst, pre, post)
`define DTPB_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif

`endif

[hdl/dtpb_pkg.sv]
// shared types and constants of the depth back-projection block
package dtpb_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DEPTH_LIMIT = 3'd0,
      CSR_SCALE_RECIP = 3'd1,
      CSR_CENTER_X    = 3'd2,
      CSR_CENTER_Y    = 3'd3,
      CSR_INV_FOCAL_X = 3'd4,
      CSR_INV_FOCAL_Y = 3'd5
   } csr_index_type;

   localparam int CSR_DATA_BITS  = 32;
   localparam int DEPTH_BITS     = 16;
   localparam int MASK_BITS      = 8;
   localparam int CHAN_BITS      = 8;
   localparam int PIX_BITS       = 12;
   localparam int CENTER_BITS    = 16;
   localparam int RECIP_BITS     = 32;
   localparam int POINT_BITS     = 32;
   localparam int REQ_TDATA_BITS = 72;
   localparam int RSP_TDATA_BITS = 120;

   // register reset values
   localparam logic [DEPTH_BITS-1:0]  RST_DEPTH_LIMIT = 16'd65535;
   localparam logic [RECIP_BITS-1:0]  RST_SCALE_RECIP = 32'd4294967;
   localparam logic [CENTER_BITS-1:0] RST_CENTER_X    = 16'd5120;
   localparam logic [CENTER_BITS-1:0] RST_CENTER_Y    = 16'd3840;
   localparam logic [RECIP_BITS-1:0]  RST_INV_FOCAL   = 32'd8180890;

   // saturation limits of a signed Q16.16 coordinate
   localparam logic [POINT_BITS-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [POINT_BITS-1:0] SAT_NEG = 32'h8000_0000;

   typedef struct packed {
      logic [CHAN_BITS-1:0] blue;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] red;
   } color_type;

   typedef struct packed {
      logic [DEPTH_BITS-1:0]  depth_limit;
      logic [RECIP_BITS-1:0]  scale_recip;
      logic [CENTER_BITS-1:0] center_x;
      logic [CENTER_BITS-1:0] center_y;
      logic [RECIP_BITS-1:0]  inv_focal_x;
      logic [RECIP_BITS-1:0]  inv_focal_y;
   } csr_type;

endpackage

[hdl/depth_to_point_backprojection_top.sv]
// top level of the pinhole depth back-projection block
// a kept pixel passes stages 1 to 4 and then the skid output register before it shows on rsp_tvalid
// throughput: one pixel per cycle, all four stages advance together while the skid is free
// a stalled output fills one skid register, then req_tready drops until it drains
// reset: synchronous, clears all valid bits and loads the register defaults
`include "depth_to_point_backprojection_top_defines.svh"

module depth_to_point_backprojection_top #(
   parameter int COORD_BITS = 12
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // depth_code[15:0], mask_value[23:16], red[31:24], green[39:32], blue[47:40],
   // pixel_row[59:48], pixel_col[71:60]
   input  logic [dtpb_pkg::REQ_TDATA_BITS-1:0]     req_tdata,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // point_x[31:0], point_y[63:32], point_z[95:64], out_red[103:96],
   // out_green[111:104], out_blue[119:112]
   output logic [dtpb_pkg::RSP_TDATA_BITS-1:0]     rsp_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [dtpb_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [dtpb_pkg::CSR_DATA_BITS-1:0]      csr_data
);
   localparam int MAG_BITS = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;

   dtpb_pkg::csr_type                csr_ff, csr_in;
   dtpb_pkg::color_type              req_color, s2_color, s3_color, s4_color;
   logic                             pipe_en;
   logic                             s2_valid, s3_valid, s4_valid;
   logic [dtpb_pkg::POINT_BITS-1:0]  s2_z, s3_z, s3_zx, s3_zy, s4_x, s4_y, s4_z;
   logic                             s2_negx, s2_negy, s3_negx, s3_negy;
   logic [MAG_BITS-1:0]              s2_magx, s2_magy, s3_magx, s3_magy;
   logic [dtpb_pkg::RSP_TDATA_BITS-1:0] s4_data;

   // configuration registers, unknown indexes are ignored
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dtpb_pkg::CSR_DEPTH_LIMIT: csr_in.depth_limit = csr_data[15:0];
            dtpb_pkg::CSR_SCALE_RECIP: csr_in.scale_recip = csr_data;
            dtpb_pkg::CSR_CENTER_X:    csr_in.center_x    = csr_data[15:0];
            dtpb_pkg::CSR_CENTER_Y:    csr_in.center_y    = csr_data[15:0];
            dtpb_pkg::CSR_INV_FOCAL_X: csr_in.inv_focal_x = csr_data;
            dtpb_pkg::CSR_INV_FOCAL_Y: csr_in.inv_focal_y = csr_data;
            default:                   csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.depth_limit <= dtpb_pkg::RST_DEPTH_LIMIT;
         csr_ff.scale_recip <= dtpb_pkg::RST_SCALE_RECIP;
         csr_ff.center_x    <= dtpb_pkg::RST_CENTER_X;
         csr_ff.center_y    <= dtpb_pkg::RST_CENTER_Y;
         csr_ff.inv_focal_x <= dtpb_pkg::RST_INV_FOCAL;
         csr_ff.inv_focal_y <= dtpb_pkg::RST_INV_FOCAL;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // the pipeline advances whenever the skid register is free
   assign req_tready = pipe_en;

   assign req_color.red   = req_tdata[31:24];
   assign req_color.green = req_tdata[39:32];
   assign req_color.blue  = req_tdata[47:40];

   dtpb_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .in_valid  (req_tvalid),
      .depth     (req_tdata[15:0]),
      .mask      (req_tdata[23:16]),
      .color     (req_color),
      .row       (req_tdata[59:48]),
      .col       (req_tdata[71:60]),
      .csr       (csr_ff),
      .out_valid (s2_valid),
      .z         (s2_z),
      .neg_x     (s2_negx),
      .mag_x     (s2_magx),
      .neg_y     (s2_negy),
      .mag_y     (s2_magy),
      .color_out (s2_color)
   );

   dtpb_focal #(
      .MAG_BITS (MAG_BITS)
   ) u_focal (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .in_valid  (s2_valid),
      .z         (s2_z),
      .neg_x     (s2_negx),
      .mag_x     (s2_magx),
      .neg_y     (s2_negy),
      .mag_y     (s2_magy),
      .color     (s2_color),
      .csr       (csr_ff),
      .out_valid (s3_valid),
      .z_out     (s3_z),
      .zx        (s3_zx),
      .zy        (s3_zy),
      .neg_x_out (s3_negx),
      .mag_x_out (s3_magx),
      .neg_y_out (s3_negy),
      .mag_y_out (s3_magy),
      .color_out (s3_color)
   );

   dtpb_proj #(
      .MAG_BITS (MAG_BITS)
   ) u_proj (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .in_valid  (s3_valid),
      .z         (s3_z),
      .zx        (s3_zx),
      .zy        (s3_zy),
      .neg_x     (s3_negx),
      .mag_x     (s3_magx),
      .neg_y     (s3_negy),
      .mag_y     (s3_magy),
      .color     (s3_color),
      .out_valid (s4_valid),
      .point_x   (s4_x),
      .point_y   (s4_y),
      .point_z   (s4_z),
      .color_out (s4_color)
   );

   // pack the result transaction
   assign s4_data = {s4_color.blue, s4_color.green, s4_color.red, s4_z, s4_y, s4_x};

   dtpb_skid #(
      .WIDTH (dtpb_pkg::RSP_TDATA_BITS)
   ) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_valid),
      .in_ready  (pipe_en),
      .in_data   (s4_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   // input stalls only while a result is held at the output
   `DTPB_ASSERT_SAME(a_stall_has_output, clock, reset, !req_tready, rsp_tvalid)
   // a zero depth coordinate gives a point at the origin
   `DTPB_ASSERT_SAME(a_zero_depth_origin, clock, reset,
      rsp_tvalid && (rsp_tdata[95:64] == 32'd0),
      (rsp_tdata[31:0] == 32'd0) && (rsp_tdata[63:32] == 32'd0))
   // a full skid register drains first once the output is taken
   `DTPB_ASSERT_NEXT(a_skid_drains, clock, reset,
      !req_tready && rsp_tready, req_tready)
endmodule

[hdl/dtpb_front.sv]
// input capture with drop filter, depth scaling and principal point offsets
module dtpb_front #(
   parameter int COORD_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pipe_en,
   input  logic                                 in_valid,
   input  logic [dtpb_pkg::DEPTH_BITS-1:0]      depth,
   input  logic [dtpb_pkg::MASK_BITS-1:0]       mask,
   input  dtpb_pkg::color_type                  color,
   input  logic [dtpb_pkg::PIX_BITS-1:0]        row,
   input  logic [dtpb_pkg::PIX_BITS-1:0]        col,
   input  dtpb_pkg::csr_type                    csr,
   output logic                                 out_valid,
   output logic [dtpb_pkg::POINT_BITS-1:0]      z,
   output logic                                 neg_x,
   output logic [((COORD_BITS+4 > 16) ? COORD_BITS+4 : 16)-1:0] mag_x,
   output logic                                 neg_y,
   output logic [((COORD_BITS+4 > 16) ? COORD_BITS+4 : 16)-1:0] mag_y,
   output dtpb_pkg::color_type                  color_out
);
   localparam int MAG_BITS  = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
   localparam int PROD_BITS = dtpb_pkg::DEPTH_BITS + dtpb_pkg::RECIP_BITS;

   logic                             valid1_ff, valid1_in;
   logic [dtpb_pkg::DEPTH_BITS-1:0]  depth1_ff;
   logic [COORD_BITS-1:0]            row1_ff, col1_ff;
   dtpb_pkg::color_type              color1_ff;

   logic                             valid2_ff;
   logic [dtpb_pkg::POINT_BITS-1:0]  z2_ff, z2_in;
   logic                             negx2_ff, negx2_in, negy2_ff, negy2_in;
   logic [MAG_BITS-1:0]              magx2_ff, magx2_in, magy2_ff, magy2_in;
   dtpb_pkg::color_type              color2_ff;

   logic [PROD_BITS-1:0]             z_prod;
   logic [MAG_BITS-1:0]              col_q4, row_q4, ctr_x, ctr_y;

   // drop pixels with zero mask, zero depth or depth at or above the limit
   assign valid1_in = in_valid && (mask != '0) && (depth != '0) && (depth < csr.depth_limit);

   // stage 1: capture the transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (pipe_en) begin
         valid1_ff <= valid1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         depth1_ff <= depth;
         row1_ff   <= COORD_BITS'(row);
         col1_ff   <= COORD_BITS'(col);
         color1_ff <= color;
      end
   end

   // depth times scale reciprocal, Q16.16
   assign z_prod = PROD_BITS'(depth1_ff) * PROD_BITS'(csr.scale_recip);
   assign z2_in  = z_prod[PROD_BITS-1 -: dtpb_pkg::POINT_BITS];

   // signed offsets from the principal point, as sign and magnitude in Q.4
   always_comb begin
      col_q4   = MAG_BITS'({col1_ff, 4'b0000});
      row_q4   = MAG_BITS'({row1_ff, 4'b0000});
      ctr_x    = MAG_BITS'(csr.center_x);
      ctr_y    = MAG_BITS'(csr.center_y);
      negx2_in = col_q4 < ctr_x;
      negy2_in = row_q4 < ctr_y;
      magx2_in = negx2_in ? (ctr_x - col_q4) : (col_q4 - ctr_x);
      magy2_in = negy2_in ? (ctr_y - row_q4) : (row_q4 - ctr_y);
   end

   // stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (pipe_en) begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         z2_ff     <= z2_in;
         negx2_ff  <= negx2_in;
         negy2_ff  <= negy2_in;
         magx2_ff  <= magx2_in;
         magy2_ff  <= magy2_in;
         color2_ff <= color1_ff;
      end
   end

   assign out_valid = valid2_ff;
   assign z         = z2_ff;
   assign neg_x     = negx2_ff;
   assign mag_x     = magx2_ff;
   assign neg_y     = negy2_ff;
   assign mag_y     = magy2_ff;
   assign color_out = color2_ff;
endmodule

[hdl/dtpb_focal.sv]
// depth times inverse focal lengths, one stage
module dtpb_focal #(
   parameter int MAG_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             pipe_en,
   input  logic                             in_valid,
   input  logic [dtpb_pkg::POINT_BITS-1:0]  z,
   input  logic                             neg_x,
   input  logic [MAG_BITS-1:0]              mag_x,
   input  logic                             neg_y,
   input  logic [MAG_BITS-1:0]              mag_y,
   input  dtpb_pkg::color_type              color,
   input  dtpb_pkg::csr_type                csr,
   output logic                             out_valid,
   output logic [dtpb_pkg::POINT_BITS-1:0]  z_out,
   output logic [dtpb_pkg::POINT_BITS-1:0]  zx,
   output logic [dtpb_pkg::POINT_BITS-1:0]  zy,
   output logic                             neg_x_out,
   output logic [MAG_BITS-1:0]              mag_x_out,
   output logic                             neg_y_out,
   output logic [MAG_BITS-1:0]              mag_y_out,
   output dtpb_pkg::color_type              color_out
);
   localparam int PROD_BITS = dtpb_pkg::POINT_BITS + dtpb_pkg::RECIP_BITS;

   logic                             valid_ff;
   logic [PROD_BITS-1:0]             zx_prod, zy_prod;
   logic [dtpb_pkg::POINT_BITS-1:0]  zx_ff, zx_in, zy_ff, zy_in, z_ff;
   logic                             negx_ff, negy_ff;
   logic [MAG_BITS-1:0]              magx_ff, magy_ff;
   dtpb_pkg::color_type              color_ff;

   // Q16.16 times Q0.32, keep Q16.16
   assign zx_prod = PROD_BITS'(z) * PROD_BITS'(csr.inv_focal_x);
   assign zy_prod = PROD_BITS'(z) * PROD_BITS'(csr.inv_focal_y);
   assign zx_in   = zx_prod[PROD_BITS-1 -: dtpb_pkg::POINT_BITS];
   assign zy_in   = zy_prod[PROD_BITS-1 -: dtpb_pkg::POINT_BITS];

   // stage 3
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pipe_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         zx_ff    <= zx_in;
         zy_ff    <= zy_in;
         z_ff     <= z;
         negx_ff  <= neg_x;
         negy_ff  <= neg_y;
         magx_ff  <= mag_x;
         magy_ff  <= mag_y;
         color_ff <= color;
      end
   end

   assign out_valid = valid_ff;
   assign z_out     = z_ff;
   assign zx        = zx_ff;
   assign zy        = zy_ff;
   assign neg_x_out = negx_ff;
   assign mag_x_out = magx_ff;
   assign neg_y_out = negy_ff;
   assign mag_y_out = magy_ff;
   assign color_out = color_ff;
endmodule

[hdl/dtpb_proj.sv]
// offset times scaled depth, truncation toward zero and saturation
module dtpb_proj #(
   parameter int MAG_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             pipe_en,
   input  logic                             in_valid,
   input  logic [dtpb_pkg::POINT_BITS-1:0]  z,
   input  logic [dtpb_pkg::POINT_BITS-1:0]  zx,
   input  logic [dtpb_pkg::POINT_BITS-1:0]  zy,
   input  logic                             neg_x,
   input  logic [MAG_BITS-1:0]              mag_x,
   input  logic                             neg_y,
   input  logic [MAG_BITS-1:0]              mag_y,
   input  dtpb_pkg::color_type              color,
   output logic                             out_valid,
   output logic [dtpb_pkg::POINT_BITS-1:0]  point_x,
   output logic [dtpb_pkg::POINT_BITS-1:0]  point_y,
   output logic [dtpb_pkg::POINT_BITS-1:0]  point_z,
   output dtpb_pkg::color_type              color_out
);
   localparam int PROD_BITS = MAG_BITS + dtpb_pkg::POINT_BITS;

   logic                             valid_ff;
   logic [dtpb_pkg::POINT_BITS-1:0]  px_ff, px_in, py_ff, py_in, z_ff;
   dtpb_pkg::color_type              color_ff;

   // magnitude product, drop the Q.4 fraction, then signed saturation
   function automatic logic [dtpb_pkg::POINT_BITS-1:0] project(
      input logic                            neg,
      input logic [MAG_BITS-1:0]             mag,
      input logic [dtpb_pkg::POINT_BITS-1:0] zf
   );
      logic [PROD_BITS-1:0] prod;
      logic [PROD_BITS-1:0] scaled;
      logic                 big;
      prod   = PROD_BITS'(mag) * PROD_BITS'(zf);
      scaled = prod >> 4;
      big    = |scaled[PROD_BITS-1:dtpb_pkg::POINT_BITS-1];
      if (neg) begin
         project = big ? dtpb_pkg::SAT_NEG : (~scaled[dtpb_pkg::POINT_BITS-1:0] + 1'b1);
      end else begin
         project = big ? dtpb_pkg::SAT_POS : scaled[dtpb_pkg::POINT_BITS-1:0];
      end
   endfunction

   assign px_in = project(neg_x, mag_x, zx);
   assign py_in = project(neg_y, mag_y, zy);

   // stage 4
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pipe_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         z_ff     <= z;
         color_ff <= color;
      end
   end

   assign out_valid = valid_ff;
   assign point_x   = px_ff;
   assign point_y   = py_ff;
   assign point_z   = z_ff;
   assign color_out = color_ff;
endmodule

[hdl/dtpb_skid.sv]
// output register with skid stage, ready upstream comes from a register
module dtpb_skid #(
   parameter int WIDTH = 120
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [WIDTH-1:0] main_data_ff, main_data_in;
   logic [WIDTH-1:0] skid_data_ff, skid_data_in;

   assign in_ready = !skid_valid_ff;

   // main register refills from skid first, else from upstream
   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_data_in  = in_data;
         end
      end else if (in_valid && in_ready) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;
endmodule
